// ----- design/fgs_pkg.sv -----
// ----------------------------------------------------------------------------
// fgs_pkg
// shared types, widths, register codes and the rule lookup for the fuzzy
// gain scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fgs_pkg;

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 17;               // magnitude of a 16-bit signed value
	localparam int BRK_W    = 16;
	localparam int MU_W     = 17;               // Q0.16 membership, 1.0 included
	localparam int GAIN_W   = 8;
	localparam int WGT_W    = 33;               // product of two memberships, max 2^32
	localparam int ACC_W    = WGT_W + GAIN_W;
	localparam int OUT_W    = 16;
	localparam int OUT_LSB  = 24;               // Q0.32 x Q8.0 down to Q8.8

	// config port
	localparam int CFG_DATA_W   = 48;
	localparam int CFG_IDX_W    = 2;
	localparam int BREAKS_W     = 3 * BRK_W;
	localparam int LEVELS_W     = 3 * GAIN_W;
	localparam int RULE_W       = 18;

	// divider and pipeline depth
	localparam int DIV_STEPS     = 16;
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;
	localparam int FUZZ_STAGES   = 2;
	localparam int DEFUZZ_STAGES = 5;
	localparam int NUM_STAGES    = FUZZ_STAGES + DIV_STAGES + DEFUZZ_STAGES;

	localparam logic [MU_W-1:0] MU_ONE = 17'h1_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGLE_BREAKS = 2'd0,
		REG_GYRO_BREAKS  = 2'd1,
		REG_GAIN_LEVELS  = 2'd2,
		REG_RULE_TABLE   = 2'd3
	} cfg_reg_t;

	localparam logic [BREAKS_W-1:0] ANGLE_BREAKS_RST = {16'd15, 16'd10, 16'd5};
	localparam logic [BREAKS_W-1:0] GYRO_BREAKS_RST  = {16'd30, 16'd15, 16'd10};
	localparam logic [LEVELS_W-1:0] GAIN_LEVELS_RST  = {8'd40, 8'd15, 8'd10};
	localparam logic [RULE_W-1:0]   RULE_TABLE_RST   = 18'd326;

	// lowest breakpoint in the least significant bits
	typedef struct packed {
		logic [BRK_W-1:0] b2;
		logic [BRK_W-1:0] b1;
		logic [BRK_W-1:0] b0;
	} breaks_t;

	typedef enum logic [1:0] {
		KIND_FULL  = 2'd0,     // below the lowest breakpoint
		KIND_EMPTY = 2'd1,     // at or above the top breakpoint
		KIND_DIV   = 2'd2      // on a slope, quotient needed
	} memb_kind_t;

	typedef struct packed {
		memb_kind_t kind;
		logic       level;
	} memb_tag_t;

	typedef struct packed {
		logic [BRK_W-1:0] num;
		logic [BRK_W-1:0] den;
		memb_tag_t        tag;
	} div_req_t;

	typedef struct packed {
		logic [MU_W-1:0] mu;
		logic            level;
	} memb_t;

	// gain singleton for one rule cell, level three reads as level two
	function automatic logic [GAIN_W-1:0] gain_lookup(
		input logic [RULE_W-1:0]   rule,
		input logic [LEVELS_W-1:0] levels,
		input logic [1:0]          row,
		input logic [1:0]          col
	);
		logic [3:0] entry;
		logic [1:0] lvl;
		entry = 4'(row * 3) + 4'(col);
		lvl   = rule[{entry, 1'b0} +: 2];
		if (lvl == 2'd3) begin
			lvl = 2'd2;
		end
		gain_lookup = levels[{lvl, 3'b000} +: GAIN_W];
	endfunction

endpackage

// ----- design/fgs_fuzzify.sv -----
// ----------------------------------------------------------------------------
// fgs_fuzzify
// magnitude of one signed sample, placement against three breakpoints and
// set-up of the slope division
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fgs_fuzzify (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [fgs_pkg::SAMPLE_W-1:0] sample,
	input  fgs_pkg::breaks_t                   breaks,
	output fgs_pkg::div_req_t                  req_s2
);

	logic [fgs_pkg::MAG_W-1:0] mag_c;
	logic [fgs_pkg::MAG_W-1:0] mag_s1;
	logic                      lt0, lt1, lt2;
	logic [fgs_pkg::BRK_W-1:0] diff1, diff2, span10, span21;
	fgs_pkg::div_req_t         req_c;

	// s1: magnitude, 0..32768
	always_comb begin
		if (sample[fgs_pkg::SAMPLE_W-1]) begin
			mag_c = 17'h1_0000 - {1'b0, sample};
		end else begin
			mag_c = {1'b0, sample};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_c;
		end
	end

	// s2: compares in priority order, spans only used where the interval is open
	always_comb begin
		lt0    = mag_s1 < {1'b0, breaks.b0};
		lt1    = mag_s1 < {1'b0, breaks.b1};
		lt2    = mag_s1 < {1'b0, breaks.b2};
		diff1  = fgs_pkg::BRK_W'({1'b0, breaks.b1} - mag_s1);
		diff2  = fgs_pkg::BRK_W'({1'b0, breaks.b2} - mag_s1);
		span10 = breaks.b1 - breaks.b0;
		span21 = breaks.b2 - breaks.b1;
		req_c.num       = '0;
		req_c.den       = '0;
		req_c.tag.kind  = fgs_pkg::KIND_EMPTY;
		req_c.tag.level = 1'b1;
		if (lt0) begin
			req_c.tag.kind  = fgs_pkg::KIND_FULL;
			req_c.tag.level = 1'b0;
		end else if (lt1) begin
			req_c.num       = diff1;
			req_c.den       = span10;
			req_c.tag.kind  = fgs_pkg::KIND_DIV;
			req_c.tag.level = 1'b0;
		end else if (lt2) begin
			req_c.num       = diff2;
			req_c.den       = span21;
			req_c.tag.kind  = fgs_pkg::KIND_DIV;
			req_c.tag.level = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s2 <= req_c;
		end
	end

endmodule

// ----- design/fgs_divider.sv -----
// ----------------------------------------------------------------------------
// fgs_divider
// pipelined restoring divider giving floor(num * 2^16 / den) for num <= den,
// a fixed number of quotient bits per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fgs_divider (
	input  logic              clk,
	input  logic              en,
	input  fgs_pkg::div_req_t req,
	output fgs_pkg::memb_t    memb
);

	typedef struct packed {
		logic [fgs_pkg::BRK_W-1:0] rem;
		logic [fgs_pkg::BRK_W-1:0] den;
		logic [fgs_pkg::BRK_W-1:0] quo;
		logic                      eq;     // num equals den, quotient is exactly one
		fgs_pkg::memb_tag_t        tag;
	} div_stage_t;

	div_stage_t pipe_s [fgs_pkg::DIV_STAGES];

	for (genvar k = 0; k < fgs_pkg::DIV_STAGES; k++) begin : g_stage
		div_stage_t prv;
		div_stage_t nxt;

		if (k == 0) begin : g_first
			always_comb begin
				prv.rem = req.num;
				prv.den = req.den;
				prv.quo = '0;
				prv.eq  = (req.num == req.den);
				prv.tag = req.tag;
			end
		end else begin : g_rest
			assign prv = pipe_s[k-1];
		end

		always_comb begin
			logic [fgs_pkg::BRK_W:0] dbl;
			nxt = prv;
			for (int i = 0; i < fgs_pkg::DIV_PER_STAGE; i++) begin
				dbl = {nxt.rem, 1'b0};
				if (dbl >= {1'b0, nxt.den}) begin
					nxt.rem = fgs_pkg::BRK_W'(dbl - {1'b0, nxt.den});
					nxt.quo = {nxt.quo[fgs_pkg::BRK_W-2:0], 1'b1};
				end else begin
					nxt.rem = dbl[fgs_pkg::BRK_W-1:0];
					nxt.quo = {nxt.quo[fgs_pkg::BRK_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[k] <= nxt;
			end
		end
	end

	// flat regions and the full-slope corner bypass the quotient
	always_comb begin
		memb.level = pipe_s[fgs_pkg::DIV_STAGES-1].tag.level;
		case (pipe_s[fgs_pkg::DIV_STAGES-1].tag.kind)
			fgs_pkg::KIND_FULL:  memb.mu = fgs_pkg::MU_ONE;
			fgs_pkg::KIND_EMPTY: memb.mu = '0;
			fgs_pkg::KIND_DIV: begin
				if (pipe_s[fgs_pkg::DIV_STAGES-1].eq) begin
					memb.mu = fgs_pkg::MU_ONE;
				end else begin
					memb.mu = {1'b0, pipe_s[fgs_pkg::DIV_STAGES-1].quo};
				end
			end
			default: memb.mu = '0;
		endcase
	end

endmodule

// ----- design/fgs_defuzz.sv -----
// ----------------------------------------------------------------------------
// fgs_defuzz
// rule lookup, corner weights and weighted sum of the gain singletons
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fgs_defuzz (
	input  logic                               clk,
	input  logic                               en,
	input  fgs_pkg::memb_t                     angle,
	input  fgs_pkg::memb_t                     gyro,
	input  logic [fgs_pkg::LEVELS_W-1:0]       gain_levels,
	input  logic [fgs_pkg::RULE_W-1:0]         rule_table,
	output logic [fgs_pkg::OUT_W-1:0]          gain_s15
);

	// corner order: 0 = (g0,a0), 1 = (g1,a0), 2 = (g0,a1), 3 = (g1,a1)
	logic [fgs_pkg::MU_W-1:0]   a0_s11, a1_s11, g0_s11, g1_s11;
	logic [fgs_pkg::GAIN_W-1:0] gain_s11 [4];
	logic [fgs_pkg::GAIN_W-1:0] gain_s12 [4];
	logic [fgs_pkg::WGT_W-1:0]  wgt_s12 [4];
	logic [fgs_pkg::ACC_W-1:0]  term_s13 [4];
	logic [fgs_pkg::ACC_W-1:0]  pair_s14 [2];
	logic [fgs_pkg::ACC_W-1:0]  sum_c;
	logic [1:0]                 row0, row1, col0, col1;

	assign row0 = {1'b0, gyro.level};
	assign row1 = row0 + 2'd1;
	assign col0 = {1'b0, angle.level};
	assign col1 = col0 + 2'd1;

	// s11: complements and singleton lookup
	always_ff @(posedge clk) begin
		if (en) begin
			a0_s11      <= angle.mu;
			a1_s11      <= fgs_pkg::MU_ONE - angle.mu;
			g0_s11      <= gyro.mu;
			g1_s11      <= fgs_pkg::MU_ONE - gyro.mu;
			gain_s11[0] <= fgs_pkg::gain_lookup(rule_table, gain_levels, row0, col0);
			gain_s11[1] <= fgs_pkg::gain_lookup(rule_table, gain_levels, row1, col0);
			gain_s11[2] <= fgs_pkg::gain_lookup(rule_table, gain_levels, row0, col1);
			gain_s11[3] <= fgs_pkg::gain_lookup(rule_table, gain_levels, row1, col1);
		end
	end

	// s12: corner weights, Q0.32
	always_ff @(posedge clk) begin
		if (en) begin
			wgt_s12[0] <= fgs_pkg::WGT_W'(g0_s11 * a0_s11);
			wgt_s12[1] <= fgs_pkg::WGT_W'(g1_s11 * a0_s11);
			wgt_s12[2] <= fgs_pkg::WGT_W'(g0_s11 * a1_s11);
			wgt_s12[3] <= fgs_pkg::WGT_W'(g1_s11 * a1_s11);
			gain_s12    <= gain_s11;
		end
	end

	// s13: weight times singleton
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				term_s13[c] <= fgs_pkg::ACC_W'(wgt_s12[c] * gain_s12[c]);
			end
		end
	end

	// s14: pairwise sums
	always_ff @(posedge clk) begin
		if (en) begin
			pair_s14[0] <= term_s13[0] + term_s13[1];
			pair_s14[1] <= term_s13[2] + term_s13[3];
		end
	end

	// s15: final sum, weights add to one so no overflow
	assign sum_c = pair_s14[0] + pair_s14[1];

	always_ff @(posedge clk) begin
		if (en) begin
			gain_s15 <= sum_c[fgs_pkg::OUT_LSB +: fgs_pkg::OUT_W];
		end
	end

endmodule

// ----- design/fuzzy_gain_scheduler.sv -----
// ----------------------------------------------------------------------------
// fuzzy_gain_scheduler
// Two-input fuzzy gain scheduler: the magnitudes of angle_error and gyro_rate
// are each placed against three programmable breakpoints, the two triangular
// memberships weight a 3x3 rule table of gain singletons, and gain_out is the
// weighted sum in unsigned Q8.8. The block is a fifteen-stage pipeline that
// takes one sample pair per clock while the output is not stalled; the depth
// is set by the membership division, a 16-step restoring divider with two
// quotient bits per stage, plus two stages in front of it and five behind it.
// A stalled output with a finished gain waiting holds the whole pipeline, so
// the input is stalled in the same cycle. No state is kept between items.
// Configuration registers take effect on the items that follow; the user must
// write them only while the pipeline is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fuzzy_gain_scheduler (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample beats
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [fgs_pkg::SAMPLE_W-1:0]  angle_error,
	input  logic signed [fgs_pkg::SAMPLE_W-1:0]  gyro_rate,
	// result beats
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [fgs_pkg::OUT_W-1:0]            gain_out,
	// configuration writes
	input  logic                                 cfg_we,
	input  logic [fgs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fgs_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// configuration registers
	logic [fgs_pkg::BREAKS_W-1:0] angle_breaks_q;
	logic [fgs_pkg::BREAKS_W-1:0] gyro_breaks_q;
	logic [fgs_pkg::LEVELS_W-1:0] gain_levels_q;
	logic [fgs_pkg::RULE_W-1:0]   rule_table_q;

	// pipeline control: one valid bit per stage, bit 0 is s1
	logic                            en;
	logic [fgs_pkg::NUM_STAGES-1:0]  vld_q;

	fgs_pkg::div_req_t angle_req_s2, gyro_req_s2;
	fgs_pkg::memb_t    angle_memb, gyro_memb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_breaks_q <= fgs_pkg::ANGLE_BREAKS_RST;
			gyro_breaks_q  <= fgs_pkg::GYRO_BREAKS_RST;
			gain_levels_q  <= fgs_pkg::GAIN_LEVELS_RST;
			rule_table_q   <= fgs_pkg::RULE_TABLE_RST;
		end else if (cfg_we) begin
			case (fgs_pkg::cfg_reg_t'(cfg_index))
				fgs_pkg::REG_ANGLE_BREAKS: angle_breaks_q <= cfg_data[fgs_pkg::BREAKS_W-1:0];
				fgs_pkg::REG_GYRO_BREAKS:  gyro_breaks_q  <= cfg_data[fgs_pkg::BREAKS_W-1:0];
				fgs_pkg::REG_GAIN_LEVELS:  gain_levels_q  <= cfg_data[fgs_pkg::LEVELS_W-1:0];
				fgs_pkg::REG_RULE_TABLE:   rule_table_q   <= cfg_data[fgs_pkg::RULE_W-1:0];
				default: ;
			endcase
		end
	end

	// the pipeline moves unless a finished beat is waiting on a stalled output
	assign en       = ~(vld_q[fgs_pkg::NUM_STAGES-1] & out_stall);
	assign in_stall = ~en;
	assign out_valid = vld_q[fgs_pkg::NUM_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[fgs_pkg::NUM_STAGES-2:0], in_valid};
		end
	end

	// s1..s2: magnitude and slope set-up, one per input
	fgs_fuzzify u_angle_fuzz (
		.clk    (clk),
		.en     (en),
		.sample (angle_error),
		.breaks (fgs_pkg::breaks_t'(angle_breaks_q)),
		.req_s2 (angle_req_s2)
	);

	fgs_fuzzify u_gyro_fuzz (
		.clk    (clk),
		.en     (en),
		.sample (gyro_rate),
		.breaks (fgs_pkg::breaks_t'(gyro_breaks_q)),
		.req_s2 (gyro_req_s2)
	);

	// s3..s10: membership quotients
	fgs_divider u_angle_div (
		.clk  (clk),
		.en   (en),
		.req  (angle_req_s2),
		.memb (angle_memb)
	);

	fgs_divider u_gyro_div (
		.clk  (clk),
		.en   (en),
		.req  (gyro_req_s2),
		.memb (gyro_memb)
	);

	// s11..s15: rule weighting and sum, s15 is the output register
	fgs_defuzz u_defuzz (
		.clk         (clk),
		.en          (en),
		.angle       (angle_memb),
		.gyro        (gyro_memb),
		.gain_levels (gain_levels_q),
		.rule_table  (rule_table_q),
		.gain_s15    (gain_out)
	);

	// weights sum to one, so the gain never exceeds the largest singleton value, 0xFF00 in Q8.8
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gain_out <= 16'hFF00)
		else $error("gain beyond largest singleton");

	// a beat in the last stage but one reaches the output on a moving edge
	a_last_shift: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_q[fgs_pkg::NUM_STAGES-2] |=> out_valid)
		else $error("beat lost before output register");

	// a held pipeline neither drops nor invents beats
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid bits moved while held");

endmodule
